### hw/rtl/rv32se_pkg.sv
`default_nettype none

package rv32se_pkg;

    localparam int DATA_BYTES = 4096;
    localparam int AW         = $clog2(DATA_BYTES);
    localparam int WORD_BYTES = 4;
    localparam int DM_ROWS    = DATA_BYTES / WORD_BYTES;
    localparam int ROW_W      = AW - 2;
    localparam int SA_W       = 12;

    localparam logic [6:0] OPC_HALT  = 7'b0000000;
    localparam logic [6:0] OPC_R     = 7'b0110011;
    localparam logic [6:0] OPC_I     = 7'b0010011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] OPC_BLT   = 7'b1100011;
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [2:0] F3_SUB    = 3'b000;
    localparam logic [2:0] F3_XOR    = 3'b100;
    localparam logic [2:0] F3_AND    = 3'b111;

    typedef enum logic [2:0] {
        K_NOP, K_HALT, K_ALU, K_LOAD, K_STORE, K_JALR, K_BLT
    } t_kind;

    typedef enum logic [2:0] {
        A_ADD, A_SUB, A_XOR, A_SRA, A_AND
    } t_alu;

    typedef enum logic [1:0] {
        S_CLR, S_RD, S_EX, S_MEM
    } t_state;

    typedef struct packed {
        t_kind       kind;
        t_alu        alu;
        logic        use_imm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } t_dec;

    typedef struct packed {
        logic valid;
        t_dec dec;
    } t_fq;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_bk;

    typedef struct packed {
        logic [31:0]     next_pc;
        logic            halted;
        logic            reg_written;
        logic [4:0]      reg_index;
        logic [31:0]     reg_value;
        logic            store_done;
        logic [SA_W-1:0] store_address;
        logic [31:0]     store_value;
    } t_res;

    typedef struct packed {
        logic        rd_en;
        logic [4:0]  ra1;
        logic [4:0]  ra2;
        logic        we;
        logic [4:0]  wa;
        logic [31:0] wd;
    } t_rf_req;

    typedef struct packed {
        logic [WORD_BYTES-1:0]            we;
        logic                             re;
        logic [WORD_BYTES-1:0][ROW_W-1:0] row;
        logic [WORD_BYTES-1:0][7:0]       wdata;
    } t_dm_req;

endpackage

`default_nettype wire

### hw/rtl/rv32se_front.sv
`default_nettype none

module rv32se_front import rv32se_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [31:0] i_instruction,
    output logic             o_full,
    output t_fq              o_fq,
    input  wire t_bk         i_bk
);

    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    t_dec       dec;
    logic       wr_en;

    t_dec       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign op = i_instruction[6:0];
    assign f3 = i_instruction[14:12];
    assign f7 = i_instruction[31:25];

    always_comb begin
        dec.kind    = K_NOP;
        dec.alu     = A_ADD;
        dec.use_imm = 1'b1;
        dec.rd      = i_instruction[11:7];
        dec.rs1     = i_instruction[19:15];
        dec.rs2     = i_instruction[24:20];
        dec.imm     = {{20{i_instruction[31]}}, i_instruction[31:20]};
        case (op)
            OPC_HALT: dec.kind = K_HALT;
            OPC_R: begin
                dec.kind    = K_ALU;
                dec.use_imm = 1'b0;
                if (f7 == F7_BASE && f3 == F3_XOR) begin
                    dec.alu = A_XOR;
                end else if (f7 == F7_ALT && f3 == F3_SUB) begin
                    dec.alu = A_SUB;
                end else if (f7 == F7_ALT) begin
                    dec.alu = A_SRA;
                end else begin
                    dec.alu = A_ADD;
                end
            end
            OPC_I: begin
                dec.kind = K_ALU;
                dec.alu  = (f3 == F3_AND) ? A_AND : A_ADD;
            end
            OPC_LOAD: dec.kind = K_LOAD;
            OPC_STORE: begin
                dec.kind = K_STORE;
                dec.imm  = {{20{i_instruction[31]}}, i_instruction[31:25],
                            i_instruction[11:7]};
            end
            OPC_JALR: dec.kind = K_JALR;
            OPC_BLT: begin
                dec.kind    = K_BLT;
                dec.use_imm = 1'b0;
                dec.imm     = {{19{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                               i_instruction[30:25], i_instruction[11:8], 1'b0};
            end
            default: dec.kind = K_NOP;
        endcase
    end

    // no beats taken while the data memory is being cleared
    assign o_full = (r_cnt == 2'd2) || i_bk.clearing;
    assign wr_en  = i_push && !o_full;

    assign o_fq.valid = (r_cnt != 2'd0);
    assign o_fq.dec   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (i_bk.take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr_en) - 2'(i_bk.take);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rv32se_regfile.sv
`default_nettype none

module rv32se_regfile import rv32se_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_rf_req i_req,
    output logic [31:0]  o_rd1,
    output logic [31:0]  o_rd2
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_rd1;
    logic [31:0] r_rd2;

    assign o_rd1 = r_rd1;
    assign o_rd2 = r_rd2;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        // entries never written read as zero, x0 is never written
        if (i_req.rd_en) begin
            r_rd1 <= r_vld[i_req.ra1] ? r_mem[i_req.ra1] : 32'd0;
            r_rd2 <= r_vld[i_req.ra2] ? r_mem[i_req.ra2] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we && i_req.wa != 5'd0) begin
            r_vld[i_req.wa] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rv32se_dmem.sv
`default_nettype none

module rv32se_dmem import rv32se_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_dm_req            i_req,
    output logic [WORD_BYTES-1:0][7:0] o_rdata
);

    for (genvar g = 0; g < WORD_BYTES; g++) begin : g_bank
        logic [7:0] r_mem [DM_ROWS];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_req.we[g]) begin
                r_mem[i_req.row[g]] <= i_req.wdata[g];
            end
            if (i_req.re) begin
                r_rd <= r_mem[i_req.row[g]];
            end
        end

        assign o_rdata[g] = r_rd;
    end

endmodule

`default_nettype wire

### hw/rtl/rv32se_back.sv
`default_nettype none

module rv32se_back import rv32se_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_fq  i_fq,
    output t_bk       o_bk,
    output logic      o_res_vld,
    output t_res      o_res,
    input  wire logic i_res_full
);

    t_state      r_state;
    t_state      n_state;
    t_dec        r_dec;
    logic [31:0] r_pc;
    logic [ROW_W-1:0] r_clr_row;

    t_rf_req     rf_req;
    t_dm_req     dm_req;
    logic [31:0] a;
    logic [31:0] b;
    logic [WORD_BYTES-1:0][7:0] dm_rdata;

    logic [31:0] opb;
    logic [31:0] sum;
    logic [31:0] alu_val;
    logic [31:0] ld_val;
    logic [31:0] pc4;
    logic [AW-1:0] ba;
    logic [31:0] ba_ext;
    logic [WORD_BYTES-1:0][ROW_W-1:0] bank_row;
    logic [WORD_BYTES-1:0][7:0] bank_wdata;
    logic [1:0]  bidx;
    logic [1:0]  lidx;
    logic [AW-1:0] baddr;
    logic        wr;
    logic [31:0] wval;
    t_res        res;

    rv32se_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_rd1   (a),
        .o_rd2   (b)
    );

    rv32se_dmem u_dmem (
        .i_clk   (i_clk),
        .i_req   (dm_req),
        .o_rdata (dm_rdata)
    );

    assign opb    = r_dec.use_imm ? r_dec.imm : b;
    assign sum    = a + opb;
    assign pc4    = r_pc + 32'd4;
    assign ba     = sum[AW-1:0];
    assign ba_ext = 32'(ba);

    always_comb begin
        case (r_dec.alu)
            A_ADD:   alu_val = sum;
            A_SUB:   alu_val = a - b;
            A_XOR:   alu_val = a ^ opb;
            A_AND:   alu_val = a & opb;
            A_SRA:   alu_val = 32'($signed(a) >>> b[4:0]);
            default: alu_val = sum;
        endcase
    end

    // a word may straddle rows: each bank gets the row of the byte that lands in it
    always_comb begin
        bidx  = 2'd0;
        baddr = '0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            bidx          = 2'(k) - ba[1:0];
            baddr         = ba + AW'(bidx);
            bank_row[k]   = baddr[AW-1:2];
            bank_wdata[k] = 8'(b >> {bidx, 3'b000});
        end
    end

    always_comb begin
        lidx = 2'd0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            lidx              = ba[1:0] + 2'(k);
            ld_val[8*k +: 8]  = dm_rdata[lidx];
        end
    end

    always_comb begin
        res         = '0;
        res.next_pc = pc4;
        wr          = 1'b0;
        wval        = 32'd0;
        case (r_dec.kind)
            K_HALT: res.halted = 1'b1;
            K_ALU: begin
                wr   = 1'b1;
                wval = alu_val;
            end
            K_LOAD: begin
                wr   = 1'b1;
                wval = ld_val;
            end
            K_STORE: begin
                res.store_done    = 1'b1;
                res.store_address = ba_ext[SA_W-1:0];
                res.store_value   = b;
            end
            K_JALR: begin
                wr          = 1'b1;
                wval        = pc4;
                res.next_pc = sum;
            end
            K_BLT: begin
                if ($signed(a) < $signed(b)) begin
                    res.next_pc = r_pc + r_dec.imm;
                end
            end
            default: res.next_pc = pc4;
        endcase
        if (wr && r_dec.rd != 5'd0) begin
            res.reg_written = 1'b1;
            res.reg_index   = r_dec.rd;
            res.reg_value   = wval;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_bk.take     = 1'b0;
        o_bk.clearing = (r_state == S_CLR);
        o_res_vld     = 1'b0;
        rf_req.rd_en  = 1'b0;
        rf_req.ra1    = i_fq.dec.rs1;
        rf_req.ra2    = i_fq.dec.rs2;
        rf_req.we     = 1'b0;
        rf_req.wa     = r_dec.rd;
        rf_req.wd     = res.reg_value;
        dm_req.we     = '0;
        dm_req.re     = 1'b0;
        dm_req.row    = bank_row;
        dm_req.wdata  = bank_wdata;
        case (r_state)
            S_CLR: begin
                dm_req.we    = '1;
                dm_req.wdata = '0;
                for (int k = 0; k < WORD_BYTES; k++) begin
                    dm_req.row[k] = r_clr_row;
                end
                if (r_clr_row == '1) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_fq.valid) begin
                    o_bk.take    = 1'b1;
                    rf_req.rd_en = 1'b1;
                    n_state      = S_EX;
                end
            end
            S_EX: begin
                if (r_dec.kind == K_LOAD) begin
                    dm_req.re = 1'b1;
                    n_state   = S_MEM;
                end else if (!i_res_full) begin
                    o_res_vld = 1'b1;
                    rf_req.we = res.reg_written;
                    if (r_dec.kind == K_STORE) begin
                        dm_req.we = '1;
                    end
                    n_state = S_RD;
                end
            end
            S_MEM: begin
                if (!i_res_full) begin
                    o_res_vld = 1'b1;
                    rf_req.we = res.reg_written;
                    n_state   = S_RD;
                end
            end
            default: n_state = S_RD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_bk.take) begin
            r_dec <= i_fq.dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 32'd0;
            r_clr_row <= '0;
        end else begin
            if (o_res_vld) begin
                r_pc <= res.next_pc;
            end
            if (r_state == S_CLR) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rv32_subset_execute_core.sv
// rv32 subset execute core
// input queue: drive i_instruction (the word fetched at the last reported pc) with push;
//   a beat is taken at a clock edge where push is high and full is low
// result queue: while empty is low the oldest result sits on the o_ ports; pop takes it
// one result beat per instruction, in order: next pc, halt flag, register write, store
// path: with both queues idle a result passes the decode queue, the register file read
//   stage and the execute step into the result queue; a load adds the data memory read
// pacing: the back-end sequencer handles one instruction at a time, through the register
//   file read stage and the execute step, plus the registered data memory read for a
//   load; meanwhile the decode queue still takes beats until it is full
// reset: pc, register file and data memory read as zero; after reset the data memory
//   is cleared one word row per cycle, and full stays high meanwhile
// stall: a 2-beat queue sits between decode and execute and another holds results; when
//   pop stays low the result queue fills, the sequencer waits, the decode queue fills
//   and full rises; nothing is dropped
`default_nettype none

module rv32_subset_execute_core import rv32se_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [31:0]     i_instruction,
    output logic                 empty,
    input  wire logic            pop,
    output logic [31:0]          o_next_pc,
    output logic                 o_halted,
    output logic                 o_reg_written,
    output logic [4:0]           o_reg_index,
    output logic [31:0]          o_reg_value,
    output logic                 o_store_done,
    output logic [SA_W-1:0]      o_store_address,
    output logic [31:0]          o_store_value
);

    t_fq        fq;
    t_bk        bk;
    logic       res_vld;
    t_res       res;
    logic       res_full;
    logic       rd_en;
    t_res       head;

    t_res       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    rv32se_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_instruction (i_instruction),
        .o_full        (full),
        .o_fq          (fq),
        .i_bk          (bk)
    );

    rv32se_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fq       (fq),
        .o_bk       (bk),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_full (res_full)
    );

    assign res_full = (r_cnt == 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign rd_en    = pop && !empty;
    assign head     = r_q[r_rp];

    assign o_next_pc       = head.next_pc;
    assign o_halted        = head.halted;
    assign o_reg_written   = head.reg_written;
    assign o_reg_index     = head.reg_index;
    assign o_reg_value     = head.reg_value;
    assign o_store_done    = head.store_done;
    assign o_store_address = head.store_address;
    assign o_store_value   = head.store_value;

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (res_vld) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(res_vld) - 2'(rd_en);
        end
    end

endmodule

`default_nettype wire

### sim/tb_rv32_subset_execute_core.sv
`timescale 1ns / 1ps

module tb_rv32_subset_execute_core;
    import rv32se_pkg::*;

    localparam logic [2:0] F3_ADDI = 3'b000;
    localparam logic [2:0] F3_WORD = 3'b010;
    localparam logic [2:0] F3_SRA  = 3'b101;
    localparam logic [2:0] F3_LT   = 3'b100;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_MARK    = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_MARK   = 900;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic [31:0]          i_instruction = '0;
    logic                 pop           = 1'b0;
    logic                 full;
    logic                 empty;
    logic [31:0]          o_next_pc;
    logic                 o_halted;
    logic                 o_reg_written;
    logic [4:0]           o_reg_index;
    logic [31:0]          o_reg_value;
    logic                 o_store_done;
    logic [SA_W-1:0]      o_store_address;
    logic [31:0]          o_store_value;

    // architectural state as the core should see it
    logic [31:0] arch_pc;
    logic [31:0] arch_gpr [32];
    logic [7:0]  arch_mem [DATA_BYTES];

    logic [31:0] pending_q [$];
    t_res        exp_q [$];

    int total_items = 0;
    int sent_count  = 0;
    int beats_seen  = 0;
    int err_count   = 0;
    int hold_left   = 0;
    bit hold_fired  = 1'b0;
    int n_load = 0, n_store = 0, n_taken = 0, n_jump = 0, n_halt = 0;

    rv32_subset_execute_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_instruction   (i_instruction),
        .empty           (empty),
        .pop             (pop),
        .o_next_pc       (o_next_pc),
        .o_halted        (o_halted),
        .o_reg_written   (o_reg_written),
        .o_reg_index     (o_reg_index),
        .o_reg_value     (o_reg_value),
        .o_store_done    (o_store_done),
        .o_store_address (o_store_address),
        .o_store_value   (o_store_value)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_R};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs1, logic [4:0] rs2);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs1, logic [4:0] rs2);
        return {off[12], off[10:5], rs2, rs1, F3_LT, off[4:1], off[11], OPC_BLT};
    endfunction

    // byte address wraps on the base first, then again after the byte offset
    function automatic int unsigned mem_index(logic [31:0] base, int unsigned k);
        return (base % DATA_BYTES + k) % DATA_BYTES;
    endfunction

    function automatic int idle_pct(bit receiver);
        if (sent_count < total_items / 3) return receiver ? 45 : 11;
        if (sent_count < 2 * total_items / 3) return receiver ? 11 : 45;
        return 0;
    endfunction

    task automatic execute_insn(input logic [31:0] insn, output t_res r);
        logic [6:0]  op;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [31:0] a, b, imm_i, imm_s, imm_b, base, wval;
        logic        wr;
        op    = insn[6:0];
        f7    = insn[31:25];
        f3    = insn[14:12];
        rd    = insn[11:7];
        a     = arch_gpr[insn[19:15]];
        b     = arch_gpr[insn[24:20]];
        imm_i = {{20{insn[31]}}, insn[31:20]};
        imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
        imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
        wr    = 1'b0;
        wval  = '0;
        r     = '0;
        r.next_pc = arch_pc + 32'd4;
        case (op)
            OPC_HALT: begin
                r.halted = 1'b1;
                n_halt++;
            end
            OPC_R: begin
                wr = 1'b1;
                if (f7 == F7_BASE && f3 == F3_XOR) wval = a ^ b;
                else if (f7 == F7_ALT && f3 == F3_SUB) wval = a - b;
                else if (f7 == F7_ALT) wval = $signed(a) >>> b[4:0];
                else wval = a + b;
            end
            OPC_I: begin
                wr   = 1'b1;
                wval = (f3 == F3_AND) ? (a & imm_i) : (a + imm_i);
            end
            OPC_LOAD: begin
                wr   = 1'b1;
                base = a + imm_i;
                for (int k = 0; k < 4; k++) wval[8*k +: 8] = arch_mem[mem_index(base, k)];
                n_load++;
            end
            OPC_STORE: begin
                base = a + imm_s;
                for (int k = 0; k < 4; k++) arch_mem[mem_index(base, k)] = b[8*k +: 8];
                r.store_done    = 1'b1;
                r.store_address = SA_W'(mem_index(base, 0));
                r.store_value   = b;
                n_store++;
            end
            OPC_JALR: begin
                wr        = 1'b1;
                wval      = arch_pc + 32'd4;
                r.next_pc = a + imm_i;
                n_jump++;
            end
            OPC_BLT: begin
                if ($signed(a) < $signed(b)) begin
                    r.next_pc = arch_pc + imm_b;
                    n_taken++;
                end
            end
            default: ;
        endcase
        if (wr && rd != 5'd0) begin
            arch_gpr[rd]  = wval;
            r.reg_written = 1'b1;
            r.reg_index   = rd;
            r.reg_value   = wval;
        end
        arch_pc = r.next_pc;
    endtask

    task automatic add_random_items();
        int          pick;
        logic [31:0] w;
        logic [6:0]  op;
        logic [11:0] imm;
        logic [4:0]  base_reg;
        pick = $urandom_range(0, 99);
        w    = $urandom();
        if (pick < 20) begin
            case ($urandom_range(0, 4))
                0, 1: w[31:25] = F7_BASE;
                2, 3: w[31:25] = F7_ALT;
                default: ;
            endcase
            w[6:0] = OPC_R;
        end else if (pick < 40) begin
            w[6:0] = OPC_I;
        end else if (pick < 50) begin
            w[6:0] = OPC_LOAD;
        end else if (pick < 60) begin
            w[6:0] = OPC_STORE;
        end else if (pick < 72) begin
            w[6:0] = OPC_BLT;
        end else if (pick < 78) begin
            w[6:0] = OPC_JALR;
        end else if (pick < 81) begin
            w[6:0] = OPC_HALT;
        end else if (pick < 86) begin
            do begin
                op = 7'($urandom_range(1, 127));
            end while (op inside {OPC_R, OPC_I, OPC_STORE, OPC_LOAD, OPC_JALR, OPC_BLT});
            w[6:0] = op;
        end else begin
            // store a word, then read it back at the same or a nearby byte address
            imm      = 12'($urandom());
            base_reg = 5'($urandom());
            pending_q.push_back(enc_s(imm, base_reg, 5'($urandom())));
            w = enc_i(OPC_LOAD, 3'($urandom()), 5'($urandom()), base_reg,
                      imm + 12'($urandom_range(0, 3)));
        end
        pending_q.push_back(w);
    endtask

    initial begin
        pending_q = '{
            enc_i(OPC_I, F3_ADDI, 5'd1, 5'd0, 12'hfff),
            enc_i(OPC_I, F3_ADDI, 5'd2, 5'd0, 12'h7ff),
            enc_i(OPC_I, F3_ADDI, 5'd3, 5'd0, 12'h800),
            enc_r(F7_BASE, F3_ADDI, 5'd4, 5'd1, 5'd2),
            enc_r(F7_ALT, F3_SUB, 5'd5, 5'd3, 5'd2),
            enc_r(F7_BASE, F3_XOR, 5'd6, 5'd1, 5'd2),
            enc_r(F7_ALT, F3_SRA, 5'd7, 5'd1, 5'd2),
            enc_r(F7_ALT, F3_AND, 5'd8, 5'd3, 5'd5),
            enc_r(7'h7f, F3_XOR, 5'd9, 5'd1, 5'd2),
            enc_i(OPC_I, F3_AND, 5'd10, 5'd1, 12'h0f0),
            enc_i(OPC_I, F3_ADDI, 5'd0, 5'd1, 12'h005),
            enc_s(12'hfff, 5'd0, 5'd6),
            enc_i(OPC_LOAD, F3_WORD, 5'd11, 5'd0, 12'hfff),
            enc_i(OPC_LOAD, F3_WORD, 5'd12, 5'd0, 12'h000),
            enc_s(12'h7ff, 5'd2, 5'd7),
            enc_i(OPC_LOAD, F3_WORD, 5'd13, 5'd2, 12'h7ff),
            enc_i(OPC_JALR, F3_ADDI, 5'd14, 5'd1, 12'h000),
            enc_i(OPC_JALR, F3_ADDI, 5'd0, 5'd2, 12'h7ff),
            enc_i(OPC_JALR, F3_ADDI, 5'd14, 5'd14, 12'h004),
            enc_b(13'h1000, 5'd1, 5'd2),
            enc_b(13'h0ffe, 5'd2, 5'd1),
            enc_b(13'h0008, 5'd3, 5'd2),
            enc_b(13'h0010, 5'd1, 5'd1),
            32'hffffff80,
            32'h00000000,
            32'hffffffff
        };
        while (pending_q.size() < 26 + RANDOM_ITEMS) add_random_items();
        total_items = pending_q.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: offers the head of the pending list, updates the prediction on each beat
    always @(posedge i_clk) begin : drive_proc
        t_res want;
        bit   send;
        bit   draining;
        if (!i_rst_n) begin
            push     <= 1'b0;
            draining = 1'b0;
            arch_pc  = '0;
            for (int k = 0; k < 32; k++) arch_gpr[k] = '0;
            for (int k = 0; k < DATA_BYTES; k++) arch_mem[k] = '0;
        end else begin
            if (push && !full) begin
                execute_insn(i_instruction, want);
                exp_q.push_back(want);
                void'(pending_q.pop_front());
                sent_count <= sent_count + 1;
                if (sent_count + 1 == DRAIN_MARK) draining = 1'b1;
            end else if (draining && beats_seen == sent_count) begin
                draining = 1'b0;
            end
            send = !draining && pending_q.size() > 0 &&
                   $urandom_range(0, 99) >= idle_pct(1'b0);
            push <= send;
            if (send) i_instruction <= pending_q[0];
        end
    end

    // long receiver hold-off so the core backs up and raises full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && sent_count >= HOLD_MARK) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = {o_next_pc, o_halted, o_reg_written, o_reg_index, o_reg_value,
                       o_store_done, o_store_address, o_store_value};
                beats_seen <= beats_seen + 1;
                if (exp_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing outstanding, next_pc %h",
                                 $realtime, o_next_pc);
                end else begin
                    want = exp_q.pop_front();
                    if (got != want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch want pc %h h %b w %b x%0d=%h st %b @%h=%h",
                                     $realtime, want.next_pc, want.halted, want.reg_written,
                                     want.reg_index, want.reg_value, want.store_done,
                                     want.store_address, want.store_value);
                            $display("%0t:          got  pc %h h %b w %b x%0d=%h st %b @%h=%h",
                                     $realtime, got.next_pc, got.halted, got.reg_written,
                                     got.reg_index, got.reg_value, got.store_done,
                                     got.store_address, got.store_value);
                        end
                    end
                end
            end
            pop <= hold_left == 0 && $urandom_range(0, 99) >= idle_pct(1'b1);
        end
    end

    initial begin : finish_proc
        int guard;
        wait (total_items != 0 && sent_count == total_items);
        guard = 0;
        while (beats_seen < sent_count && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (exp_q.size() != 0) begin
            $display("%0d results never arrived", exp_q.size());
            err_count += exp_q.size();
        end
        $display("executed %0d instructions: %0d loads, %0d stores, %0d jumps, %0d taken blt, %0d halts",
                 sent_count, n_load, n_store, n_jump, n_taken, n_halt);
        $display("checked %0d result beats across three idle mixes, one backpressure stall and one drain",
                 beats_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d of %0d instructions sent", sent_count, total_items);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rv32se_pkg.sv
hw/rtl/rv32se_front.sv
hw/rtl/rv32se_regfile.sv
hw/rtl/rv32se_dmem.sv
hw/rtl/rv32se_back.sv
hw/rtl/rv32_subset_execute_core.sv
sim/tb_rv32_subset_execute_core.sv
